FILE: src/hne_pkg.sv
package hne_pkg;

   // bits of one encoded channel
   localparam int unsigned CODE_BITS = 8;

   // 255 * 255, the square of the encoding scale
   localparam logic [15:0] SCALE_SQ = 16'd65025;

   // grid spacing after reset, unsigned Q16.16 (about 39135.7575)
   localparam logic [31:0] SPACING_RESET = 32'd2564801003;

   // encoded value of a zero-length normal
   localparam logic [CODE_BITS-1:0] CODE_MID = 8'd127;

endpackage

FILE: src/heightfield_normal_encoder_top.sv
// Height-field normal encoder. Takes the four neighbor heights of one pixel and
// returns the unit normal encoded as red, green and blue bytes, each
// floor((n+1)*127.5), exact to the bit. A new item is taken every clock: busy
// is never raised, and each result is shown for one cycle under rsp_strobe;
// the receiver cannot stall, so it must take every result as it comes. The
// result passes difference, squaring and scaling stages, then eight steps of a
// bit-by-bit search per channel, each with candidate, multiply and compare
// stages and one multiplier of the squared length by a small square. The user
// must write the grid spacing through the csr port only while no item is in
// flight; the block does not enforce it. A zero spacing gives 127 on every channel.
module heightfield_normal_encoder_top #(
   parameter int unsigned HEIGHT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [HEIGHT_BITS-1:0] req_height_left,
   input  logic signed [HEIGHT_BITS-1:0] req_height_right,
   input  logic signed [HEIGHT_BITS-1:0] req_height_top,
   input  logic signed [HEIGHT_BITS-1:0] req_height_bottom,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [31:0]                   csr_data
);

   localparam int unsigned QA = 2 * HEIGHT_BITS + 33;
   localparam int unsigned QW = ((QA > 64) ? QA : 64) + 1;
   localparam int unsigned RA = 2 * HEIGHT_BITS + 48;
   localparam int unsigned RW = (RA > 80) ? RA : 80;
   localparam int unsigned NB = hne_pkg::CODE_BITS;

   // spacing register
   logic [31:0] spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= hne_pkg::SPACING_RESET;
      end else if (csr_valid && csr_ready) begin
         spacing_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // front end
   logic          pv;
   logic [QW-1:0] pq;
   logic [RW-1:0] prx, pry, prz;
   logic          pnx, pny;

   hne_prep #(.HEIGHT_BITS(HEIGHT_BITS), .QW(QW), .RW(RW)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_left   (req_height_left),
      .in_right  (req_height_right),
      .in_top    (req_height_top),
      .in_bottom (req_height_bottom),
      .in_spacing(spacing_ff),
      .out_valid (pv),
      .out_q     (pq),
      .out_rhs_x (prx),
      .out_rhs_y (pry),
      .out_rhs_z (prz),
      .out_neg_x (pnx),
      .out_neg_y (pny)
   );

   // per-channel search chains, most significant bit first
   logic          v_ch [3][NB+1];
   logic [NB-1:0] k_ch [3][NB+1];
   logic [QW-1:0] q_ch [3][NB+1];
   logic [RW-1:0] r_ch [3][NB+1];
   logic          n_ch [3][NB+1];

   for (genvar c = 0; c < 3; c++) begin : g_head
      assign v_ch[c][0] = pv;
      assign k_ch[c][0] = '0;
      assign q_ch[c][0] = pq;
   end

   assign r_ch[0][0] = prx;
   assign r_ch[1][0] = pry;
   assign r_ch[2][0] = prz;
   assign n_ch[0][0] = pnx;
   assign n_ch[1][0] = pny;
   assign n_ch[2][0] = 1'b0;

   for (genvar c = 0; c < 3; c++) begin : g_chan
      for (genvar i = 0; i < NB; i++) begin : g_bit
         hne_bit_step #(.QW(QW), .RW(RW), .BIT(NB - 1 - i)) u_step (
            .clock    (clock),
            .reset    (reset),
            .in_valid (v_ch[c][i]),
            .in_code  (k_ch[c][i]),
            .in_q     (q_ch[c][i]),
            .in_rhs   (r_ch[c][i]),
            .in_neg   (n_ch[c][i]),
            .out_valid(v_ch[c][i+1]),
            .out_code (k_ch[c][i+1]),
            .out_q    (q_ch[c][i+1]),
            .out_rhs  (r_ch[c][i+1]),
            .out_neg  (n_ch[c][i+1])
         );
      end
   end

   // result
   assign rsp_strobe = v_ch[0][NB];
   assign rsp_red    = k_ch[0][NB];
   assign rsp_green  = k_ch[1][NB];
   assign rsp_blue   = k_ch[2][NB];

endmodule

FILE: src/hne_prep.sv
module hne_prep #(
   parameter int unsigned HEIGHT_BITS = 16,
   parameter int unsigned QW = 66,
   parameter int unsigned RW = 80
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [HEIGHT_BITS-1:0] in_left,
   input  logic signed [HEIGHT_BITS-1:0] in_right,
   input  logic signed [HEIGHT_BITS-1:0] in_top,
   input  logic signed [HEIGHT_BITS-1:0] in_bottom,
   input  logic [31:0]                   in_spacing,
   output logic                          out_valid,
   output logic [QW-1:0]                 out_q,
   output logic [RW-1:0]                 out_rhs_x,
   output logic [RW-1:0]                 out_rhs_y,
   output logic [RW-1:0]                 out_rhs_z,
   output logic                          out_neg_x,
   output logic                          out_neg_y
);

   localparam int unsigned SW = 2 * HEIGHT_BITS;

   // stage 1: differences split into sign and magnitude
   logic signed [HEIGHT_BITS:0] diff_a, diff_b;
   logic                        v1_ff, na1_ff, nb1_ff;
   logic [HEIGHT_BITS-1:0]      ma1_ff, mb1_ff, ma1_in, mb1_in;
   logic [31:0]                 s1_ff;

   assign diff_a = {in_left[HEIGHT_BITS-1], in_left} - {in_right[HEIGHT_BITS-1], in_right};
   assign diff_b = {in_bottom[HEIGHT_BITS-1], in_bottom} - {in_top[HEIGHT_BITS-1], in_top};

   always_comb begin
      ma1_in = diff_a[HEIGHT_BITS] ? HEIGHT_BITS'(-diff_a) : HEIGHT_BITS'(diff_a);
      mb1_in = diff_b[HEIGHT_BITS] ? HEIGHT_BITS'(-diff_b) : HEIGHT_BITS'(diff_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      na1_ff <= diff_a[HEIGHT_BITS];
      nb1_ff <= diff_b[HEIGHT_BITS];
      ma1_ff <= ma1_in;
      mb1_ff <= mb1_in;
      s1_ff  <= in_spacing;
   end

   // stage 2: squares
   logic          v2_ff, na2_ff, nb2_ff, sz2_ff;
   logic [SW-1:0] asq2_ff, bsq2_ff;
   logic [63:0]   ssq2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      na2_ff  <= na1_ff;
      nb2_ff  <= nb1_ff;
      sz2_ff  <= (s1_ff == 32'd0);
      asq2_ff <= SW'(ma1_ff) * SW'(ma1_ff);
      bsq2_ff <= SW'(mb1_ff) * SW'(mb1_ff);
      ssq2_ff <= 64'(s1_ff) * 64'(s1_ff);
   end

   // stage 3: squared length and scaled squared components
   logic [SW:0]   sum_sq;
   logic [QW-1:0] q3_in;
   logic [RW-1:0] rx3_in, ry3_in, rz3_in;
   logic          v3_ff;

   assign sum_sq = (SW + 1)'(asq2_ff) + (SW + 1)'(bsq2_ff);

   always_comb begin
      if (sz2_ff) begin
         // zero spacing: bounds chosen so every channel settles at mid scale
         q3_in  = QW'(1);
         rx3_in = '0;
         ry3_in = '0;
         rz3_in = '0;
      end else begin
         q3_in  = (QW'(sum_sq) << 32) + QW'(ssq2_ff);
         rx3_in = RW'(asq2_ff * (SW + 16)'(hne_pkg::SCALE_SQ)) << 32;
         ry3_in = RW'(bsq2_ff * (SW + 16)'(hne_pkg::SCALE_SQ)) << 32;
         rz3_in = RW'(ssq2_ff * 80'(hne_pkg::SCALE_SQ));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      out_q     <= q3_in;
      out_rhs_x <= rx3_in;
      out_rhs_y <= ry3_in;
      out_rhs_z <= rz3_in;
      out_neg_x <= na2_ff & ~sz2_ff;
      out_neg_y <= nb2_ff & ~sz2_ff;
   end

   assign out_valid = v3_ff;

endmodule

FILE: src/hne_bit_step.sv
module hne_bit_step #(
   parameter int unsigned QW = 66,
   parameter int unsigned RW = 80,
   parameter int unsigned BIT = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [hne_pkg::CODE_BITS-1:0]   in_code,
   input  logic [QW-1:0]                   in_q,
   input  logic [RW-1:0]                   in_rhs,
   input  logic                            in_neg,
   output logic                            out_valid,
   output logic [hne_pkg::CODE_BITS-1:0]   out_code,
   output logic [QW-1:0]                   out_q,
   output logic [RW-1:0]                   out_rhs,
   output logic                            out_neg
);

   localparam int unsigned LW = QW + 16;
   localparam int unsigned CW = (LW > RW) ? LW : RW;

   // stage a: candidate code and square of its odd multiplier 2k-255
   logic [hne_pkg::CODE_BITS-1:0] cand_in, cand_a_ff, cand_b_ff;
   logic [7:0]                    mabs_in;
   logic [15:0]                   msq_a_ff;
   logic                          va_ff, vb_ff, nega_ff, negb_ff;
   logic [QW-1:0]                 qa_ff;
   logic [RW-1:0]                 ra_ff, rb_ff;
   logic [hne_pkg::CODE_BITS-1:0] ka_ff, kb_ff;

   always_comb begin
      cand_in = in_code | (hne_pkg::CODE_BITS'(1) << BIT);
      mabs_in = cand_in[7] ? {cand_in[6:0], 1'b1} : {~cand_in[6:0], 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
      cand_a_ff <= cand_in;
      msq_a_ff  <= 16'(mabs_in) * 16'(mabs_in);
      nega_ff   <= in_neg;
      qa_ff     <= in_q;
      ra_ff     <= in_rhs;
      ka_ff     <= in_code;
   end

   // stage b: scaled squared length
   logic [LW-1:0] lhs_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      lhs_b_ff  <= LW'(qa_ff) * LW'(msq_a_ff);
      cand_b_ff <= cand_a_ff;
      negb_ff   <= nega_ff;
      rb_ff     <= ra_ff;
      kb_ff     <= ka_ff;
   end

   // stage c: keep the candidate bit when the bound still holds
   logic [CW-1:0] lhs_c, rhs_c;
   logic          keep;
   logic          vc_ff;
   logic [QW-1:0] qb_ff;

   always_ff @(posedge clock) begin
      qb_ff <= qa_ff;
   end

   always_comb begin
      lhs_c = CW'(lhs_b_ff);
      rhs_c = CW'(rb_ff);
      if (cand_b_ff[7]) begin
         keep = ~negb_ff && (lhs_c <= rhs_c);
      end else if (negb_ff) begin
         keep = (lhs_c >= rhs_c);
      end else begin
         keep = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= vb_ff;
      end
      out_code <= keep ? cand_b_ff : kb_ff;
      out_q    <= qb_ff;
      out_rhs  <= rb_ff;
      out_neg  <= negb_ff;
   end

   assign out_valid = vc_ff;

endmodule
